/* hdl/d2p_pkg.sv */
// Shared widths, reset values, register indexes and pipeline word types
// for the disparity-to-point reprojection core. No dependencies.
package d2p_pkg;

   localparam int DISP_W     = 16;
   localparam int COORD_W    = 12;
   localparam int DIM_W      = 13;
   localparam int STRIDE_W   = 7;
   localparam int SCALE_W    = 24;
   localparam int FRAC_IN_W  = 4;
   localparam int CENTER_W   = 20;
   localparam int INV_W      = 32;
   localparam int Z_W        = 28;
   localparam int DIVISOR_W  = 15;
   localparam int SUBPIX_W   = 8;
   localparam int DIFF_W     = 21;
   localparam int MAG_W      = 20;
   localparam int PROD_W     = 48;
   localparam int HALF_W     = 24;
   localparam int PP_W       = HALF_W + INV_W;
   localparam int SUM_W      = PP_W + HALF_W;
   localparam int Q_W        = 40;
   localparam int OUT_W      = 32;
   localparam int DIV_CELLS  = Z_W;
   localparam int MOD_CELLS  = COORD_W;
   localparam int PROJ_STAGES = 5;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [DIM_W-1:0]    RST_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_W-1:0]    RST_IMAGE_HEIGHT = 13'd480;
   localparam logic [STRIDE_W-1:0] RST_STRIDE       = 7'd8;
   localparam logic [SCALE_W-1:0]  RST_DEPTH_SCALE  = 24'd615358;
   localparam logic [CENTER_W-1:0] RST_CENTER_X     = 20'd86698;
   localparam logic [CENTER_W-1:0] RST_CENTER_Y     = 20'd66044;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_X  = 32'd5713622;
   localparam logic [INV_W-1:0]    RST_INV_FOCAL_Y  = 32'd5604690;

   localparam logic [Q_W-1:0] SAT_POS_MAG = Q_W'(32'h7FFF_FFFF);
   localparam logic [Q_W-1:0] SAT_NEG_MAG = Q_W'(32'h8000_0000);

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 3'd0,
      CSR_IMAGE_HEIGHT = 3'd1,
      CSR_SAMPLE_STRIDE = 3'd2,
      CSR_DEPTH_SCALE  = 3'd3,
      CSR_CENTER_X     = 3'd4,
      CSR_CENTER_Y     = 3'd5,
      CSR_INV_FOCAL_X  = 3'd6,
      CSR_INV_FOCAL_Y  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [DIM_W-1:0]    image_width;
      logic [DIM_W-1:0]    image_height;
      logic [STRIDE_W-1:0] stride;       // a stride of zero already reads as one
      logic [SCALE_W-1:0]  depth_scale;
      logic [CENTER_W-1:0] center_x;
      logic [CENTER_W-1:0] center_y;
      logic [INV_W-1:0]    inv_focal_x;
      logic [INV_W-1:0]    inv_focal_y;
   } cfg_type;

   // Word handed from cell to cell along the division chain.
   typedef struct packed {
      logic [DIVISOR_W-1:0]    rem;
      logic [Z_W-1:0]          work;     // dividend bits out at the top, quotient in below
      logic [DIVISOR_W-1:0]    divisor;
      logic [STRIDE_W-1:0]     col_rem;
      logic [STRIDE_W-1:0]     row_rem;
      logic [COORD_W-1:0]      col_bits;
      logic [COORD_W-1:0]      row_bits;
      logic [COORD_W-1:0]      col;
      logic [COORD_W-1:0]      row;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
   } div_item_type;

endpackage

/* hdl/d2p_if.sv */
// Valid/ready channel interfaces for the request and response streams of
// the reprojection core. No dependencies.
interface d2p_req_if;
   logic              valid;
   logic              ready;
   logic signed [15:0] disparity_raw;
   logic              frame_start;

   modport source (output valid, output disparity_raw, output frame_start, input ready);
   modport sink (input valid, input disparity_raw, input frame_start, output ready);
endinterface

interface d2p_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] point_x;
   logic signed [31:0] point_y;
   logic [27:0]        point_z;
   logic [11:0]        pixel_col;
   logic [11:0]        pixel_row;

   modport source (output valid, output point_x, output point_y, output point_z,
                   output pixel_col, output pixel_row, input ready);
   modport sink (input valid, input point_x, input point_y, input point_z,
                 input pixel_col, input pixel_row, output ready);
endinterface

/* hdl/d2p_csr.sv */
// Configuration register file of the reprojection core.
// Depends on d2p_pkg.
module d2p_csr import d2p_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [DIM_W-1:0]    width_ff;
   logic [DIM_W-1:0]    height_ff;
   logic [STRIDE_W-1:0] stride_ff;
   logic [SCALE_W-1:0]  scale_ff;
   logic [CENTER_W-1:0] center_x_ff;
   logic [CENTER_W-1:0] center_y_ff;
   logic [INV_W-1:0]    inv_x_ff;
   logic [INV_W-1:0]    inv_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= RST_IMAGE_WIDTH;
         height_ff   <= RST_IMAGE_HEIGHT;
         stride_ff   <= RST_STRIDE;
         scale_ff    <= RST_DEPTH_SCALE;
         center_x_ff <= RST_CENTER_X;
         center_y_ff <= RST_CENTER_Y;
         inv_x_ff    <= RST_INV_FOCAL_X;
         inv_y_ff    <= RST_INV_FOCAL_Y;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_IMAGE_WIDTH: begin
               width_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_IMAGE_HEIGHT: begin
               height_ff <= csr_wdata[DIM_W-1:0];
            end
            CSR_SAMPLE_STRIDE: begin
               stride_ff <= csr_wdata[STRIDE_W-1:0];
            end
            CSR_DEPTH_SCALE: begin
               scale_ff <= csr_wdata[SCALE_W-1:0];
            end
            CSR_CENTER_X: begin
               center_x_ff <= csr_wdata[CENTER_W-1:0];
            end
            CSR_CENTER_Y: begin
               center_y_ff <= csr_wdata[CENTER_W-1:0];
            end
            CSR_INV_FOCAL_X: begin
               inv_x_ff <= csr_wdata[INV_W-1:0];
            end
            CSR_INV_FOCAL_Y: begin
               inv_y_ff <= csr_wdata[INV_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.image_width  = width_ff;
      cfg.image_height = height_ff;
      cfg.stride       = (stride_ff == '0) ? STRIDE_W'(1) : stride_ff;
      cfg.depth_scale  = scale_ff;
      cfg.center_x     = center_x_ff;
      cfg.center_y     = center_y_ff;
      cfg.inv_focal_x  = inv_x_ff;
      cfg.inv_focal_y  = inv_y_ff;
   end

endmodule

/* hdl/d2p_scan.sv */
// Raster position tracker and entry stage of the division chain: keeps the
// column and row counters and forms the word for the first cell.
// Depends on d2p_pkg and d2p_if.
module d2p_scan import d2p_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   d2p_req_if.sink      req_chan,
   output logic         out_valid,
   output div_item_type out_item,
   input  logic         out_go
);

   logic [COORD_W-1:0] column_count_ff, column_count_in;
   logic [COORD_W-1:0] row_count_ff, row_count_in;
   logic               valid_ff, valid_in;
   div_item_type       item_ff, item_in;

   logic               go;
   logic               accept;
   logic [COORD_W-1:0] col_cur, row_cur;
   logic [DIM_W-1:0]   col_inc, row_inc;
   logic signed [DIM_W:0] col_lim, row_lim;
   logic               in_grid;
   logic               disp_pos;
   div_item_type       entry;

   assign go             = !valid_ff || out_go;
   assign req_chan.ready = go;
   assign accept         = req_chan.valid && go;

   always_comb begin
      col_cur = req_chan.frame_start ? '0 : column_count_ff;
      row_cur = req_chan.frame_start ? '0 : row_count_ff;
      col_inc = {1'b0, col_cur} + DIM_W'(1);
      row_inc = {1'b0, row_cur} + DIM_W'(1);

      column_count_in = column_count_ff;
      row_count_in    = row_count_ff;
      if (accept) begin
         if (col_inc >= cfg.image_width) begin
            column_count_in = '0;
            row_count_in    = (row_inc >= cfg.image_height) ? '0 : row_inc[COORD_W-1:0];
         end else begin
            column_count_in = col_inc[COORD_W-1:0];
            row_count_in    = row_cur;
         end
      end

      // Limits may go negative when the stride exceeds the image size.
      col_lim = $signed({1'b0, cfg.image_width})
              - $signed({{(DIM_W + 1 - STRIDE_W){1'b0}}, cfg.stride});
      row_lim = $signed({1'b0, cfg.image_height})
              - $signed({{(DIM_W + 1 - STRIDE_W){1'b0}}, cfg.stride});
      in_grid  = ($signed({2'b00, col_cur}) < col_lim) && ($signed({2'b00, row_cur}) < row_lim);
      disp_pos = !req_chan.disparity_raw[DISP_W-1] && (req_chan.disparity_raw[DISP_W-2:0] != '0);

      entry.rem      = '0;
      entry.work     = {cfg.depth_scale, FRAC_IN_W'(0)};
      entry.divisor  = req_chan.disparity_raw[DIVISOR_W-1:0];
      entry.col_rem  = '0;
      entry.row_rem  = '0;
      entry.col_bits = col_cur;
      entry.row_bits = row_cur;
      entry.col      = col_cur;
      entry.row      = row_cur;
      entry.dx       = $signed({1'b0, col_cur, SUBPIX_W'(0)}) - $signed({1'b0, cfg.center_x});
      entry.dy       = $signed({1'b0, row_cur, SUBPIX_W'(0)}) - $signed({1'b0, cfg.center_y});

      // The stride grid test on column and row is finished along the chain.
      valid_in = go ? (accept && disp_pos && in_grid) : valid_ff;
      item_in  = go ? entry : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_count_ff <= '0;
         row_count_ff    <= '0;
         valid_ff        <= 1'b0;
      end else begin
         column_count_ff <= column_count_in;
         row_count_ff    <= row_count_in;
         valid_ff        <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* hdl/d2p_div_cell.sv */
// One cell of the division chain: a restoring step of the depth quotient,
// and, where enabled, one step of column and row modulo the stride.
// Depends on d2p_pkg.
module d2p_div_cell import d2p_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [STRIDE_W-1:0] stride,
   input  logic                mod_step,
   input  logic                in_valid,
   input  div_item_type        in_item,
   output logic                in_go,
   output logic                out_valid,
   output div_item_type        out_item,
   input  logic                out_go
);

   logic         valid_ff, valid_in;
   div_item_type item_ff, item_in;
   div_item_type step;

   logic [DIVISOR_W:0]  trial, trial_diff;
   logic                take;
   logic [STRIDE_W:0]   col_trial, col_diff, row_trial, row_diff;
   logic                col_take, row_take;

   assign in_go = !valid_ff || out_go;

   always_comb begin
      step = in_item;

      trial      = {in_item.rem, in_item.work[Z_W-1]};
      trial_diff = trial - {1'b0, in_item.divisor};
      take       = trial >= {1'b0, in_item.divisor};
      step.rem   = take ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      step.work  = {in_item.work[Z_W-2:0], take};

      col_trial = {in_item.col_rem, in_item.col_bits[COORD_W-1]};
      col_diff  = col_trial - {1'b0, stride};
      col_take  = col_trial >= {1'b0, stride};
      row_trial = {in_item.row_rem, in_item.row_bits[COORD_W-1]};
      row_diff  = row_trial - {1'b0, stride};
      row_take  = row_trial >= {1'b0, stride};
      if (mod_step) begin
         step.col_rem  = col_take ? col_diff[STRIDE_W-1:0] : col_trial[STRIDE_W-1:0];
         step.row_rem  = row_take ? row_diff[STRIDE_W-1:0] : row_trial[STRIDE_W-1:0];
         step.col_bits = {in_item.col_bits[COORD_W-2:0], 1'b0};
         step.row_bits = {in_item.row_bits[COORD_W-2:0], 1'b0};
      end

      valid_in = in_go ? in_valid : valid_ff;
      item_in  = in_go ? step : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* hdl/d2p_project.sv */
// Projection pipeline: drops words off the stride grid, scales the centred
// column and row by depth and inverse focal length, saturates, and holds
// the response register. Depends on d2p_pkg and d2p_if.
module d2p_project import d2p_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         in_valid,
   input  div_item_type in_item,
   output logic         in_go,
   d2p_rsp_if.source    rsp_chan
);

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic [MAG_W-1:0]   mag_x;
      logic [MAG_W-1:0]   mag_y;
      logic [Z_W-1:0]     z;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } abs_type;

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic [PROD_W-1:0]  px;
      logic [PROD_W-1:0]  py;
      logic [Z_W-1:0]     z;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } prod_type;

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic [PP_W-1:0]    hx;
      logic [PP_W-1:0]    lx;
      logic [PP_W-1:0]    hy;
      logic [PP_W-1:0]    ly;
      logic [Z_W-1:0]     z;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } part_type;

   typedef struct packed {
      logic               neg_x;
      logic               neg_y;
      logic [Q_W-1:0]     qx;
      logic [Q_W-1:0]     qy;
      logic [Z_W-1:0]     z;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } quot_type;

   typedef struct packed {
      logic [OUT_W-1:0]   x;
      logic [OUT_W-1:0]   y;
      logic [Z_W-1:0]     z;
      logic [COORD_W-1:0] col;
      logic [COORD_W-1:0] row;
   } point_type;

   function automatic logic [OUT_W-1:0] clamp(input logic neg, input logic [Q_W-1:0] q);
      logic [Q_W-1:0] lim;
      logic [Q_W-1:0] qs;
      lim = neg ? SAT_NEG_MAG : SAT_POS_MAG;
      qs  = (q > lim) ? lim : q;
      return neg ? (OUT_W'(0) - qs[OUT_W-1:0]) : qs[OUT_W-1:0];
   endfunction

   logic [PROJ_STAGES-1:0] valid_ff, valid_in;
   logic [PROJ_STAGES:0]   go;
   logic                   keep;

   abs_type   s0_ff, s0_in;
   prod_type  s1_ff, s1_in;
   part_type  s2_ff, s2_in;
   quot_type  s3_ff, s3_in;
   point_type s4_ff, s4_in;

   logic [SUM_W-1:0] sum_x, sum_y;
   logic [DIFF_W-1:0] neg_dx, neg_dy;

   always_comb begin
      go[PROJ_STAGES] = rsp_chan.ready;
      for (int i = PROJ_STAGES - 1; i >= 0; i--) begin
         go[i] = !valid_ff[i] || go[i+1];
      end
   end

   assign in_go = go[0];

   // Only words whose column and row sit on the stride grid go on.
   assign keep = in_valid && (in_item.col_rem == '0) && (in_item.row_rem == '0);

   always_comb begin
      valid_in[0] = go[0] ? keep : valid_ff[0];
      for (int i = 1; i < PROJ_STAGES; i++) begin
         valid_in[i] = go[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_comb begin
      neg_dx = DIFF_W'(0) - in_item.dx;
      neg_dy = DIFF_W'(0) - in_item.dy;

      s0_in = s0_ff;
      if (go[0]) begin
         s0_in.neg_x = in_item.dx[DIFF_W-1];
         s0_in.neg_y = in_item.dy[DIFF_W-1];
         s0_in.mag_x = in_item.dx[DIFF_W-1] ? neg_dx[MAG_W-1:0] : in_item.dx[MAG_W-1:0];
         s0_in.mag_y = in_item.dy[DIFF_W-1] ? neg_dy[MAG_W-1:0] : in_item.dy[MAG_W-1:0];
         s0_in.z     = in_item.work;
         s0_in.col   = in_item.col;
         s0_in.row   = in_item.row;
      end

      s1_in = s1_ff;
      if (go[1]) begin
         s1_in.neg_x = s0_ff.neg_x;
         s1_in.neg_y = s0_ff.neg_y;
         s1_in.px    = PROD_W'(s0_ff.mag_x) * PROD_W'(s0_ff.z);
         s1_in.py    = PROD_W'(s0_ff.mag_y) * PROD_W'(s0_ff.z);
         s1_in.z     = s0_ff.z;
         s1_in.col   = s0_ff.col;
         s1_in.row   = s0_ff.row;
      end

      // The 48 bit product is split into 24 bit halves, each times 32 bits.
      s2_in = s2_ff;
      if (go[2]) begin
         s2_in.neg_x = s1_ff.neg_x;
         s2_in.neg_y = s1_ff.neg_y;
         s2_in.hx    = PP_W'(s1_ff.px[PROD_W-1:HALF_W]) * PP_W'(cfg.inv_focal_x);
         s2_in.lx    = PP_W'(s1_ff.px[HALF_W-1:0]) * PP_W'(cfg.inv_focal_x);
         s2_in.hy    = PP_W'(s1_ff.py[PROD_W-1:HALF_W]) * PP_W'(cfg.inv_focal_y);
         s2_in.ly    = PP_W'(s1_ff.py[HALF_W-1:0]) * PP_W'(cfg.inv_focal_y);
         s2_in.z     = s1_ff.z;
         s2_in.col   = s1_ff.col;
         s2_in.row   = s1_ff.row;
      end

      sum_x = {s2_ff.hx, HALF_W'(0)} + SUM_W'(s2_ff.lx);
      sum_y = {s2_ff.hy, HALF_W'(0)} + SUM_W'(s2_ff.ly);
      s3_in = s3_ff;
      if (go[3]) begin
         s3_in.neg_x = s2_ff.neg_x;
         s3_in.neg_y = s2_ff.neg_y;
         s3_in.qx    = sum_x[SUM_W-1:SUM_W-Q_W];
         s3_in.qy    = sum_y[SUM_W-1:SUM_W-Q_W];
         s3_in.z     = s2_ff.z;
         s3_in.col   = s2_ff.col;
         s3_in.row   = s2_ff.row;
      end

      s4_in = s4_ff;
      if (go[4]) begin
         s4_in.x   = clamp(s3_ff.neg_x, s3_ff.qx);
         s4_in.y   = clamp(s3_ff.neg_y, s3_ff.qy);
         s4_in.z   = s3_ff.z;
         s4_in.col = s3_ff.col;
         s4_in.row = s3_ff.row;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s0_ff <= s0_in;
      s1_ff <= s1_in;
      s2_ff <= s2_in;
      s3_ff <= s3_in;
      s4_ff <= s4_in;
   end

   assign rsp_chan.valid     = valid_ff[PROJ_STAGES-1];
   assign rsp_chan.point_x   = $signed(s4_ff.x);
   assign rsp_chan.point_y   = $signed(s4_ff.y);
   assign rsp_chan.point_z   = s4_ff.z;
   assign rsp_chan.pixel_col = s4_ff.col;
   assign rsp_chan.pixel_row = s4_ff.row;

endmodule

/* hdl/disparity_to_point_reprojection_core.sv */
// Top level of the disparity-to-point reprojection core.
// Depends on d2p_pkg, d2p_if, d2p_csr, d2p_scan, d2p_div_cell, d2p_project.
//
//   Port      Direction  Word                                   Handshake
//   req_chan  in         disparity_raw, frame_start             valid / ready
//   rsp_chan  out        point_x, point_y, point_z, col, row    valid / ready
//   csr_*     in         csr_index, csr_wdata                   csr_write_en
//
// One word is taken every cycle while the output is not stalled; a point
// passes the entry stage, 28 division cells and five projection stages.
// Pixels that give no point leave a bubble that later words close up.
// Every stage holds its word while the next is full and held, so input
// keeps flowing until the whole chain is full behind a stalled output.
// Reset is synchronous and clears the counters and all valid flags.
module disparity_to_point_reprojection_core import d2p_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   d2p_req_if.sink               req_chan,
   d2p_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_ADDR_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type      cfg;
   logic         chain_valid [DIV_CELLS+1];
   div_item_type chain_item  [DIV_CELLS+1];
   logic         chain_go    [DIV_CELLS+1];

   d2p_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   d2p_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_chan  (req_chan),
      .out_valid (chain_valid[0]),
      .out_item  (chain_item[0]),
      .out_go    (chain_go[0])
   );

   // The first cells also reduce column and row modulo the stride.
   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_cell
      d2p_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stride    (cfg.stride),
         .mod_step  (k < MOD_CELLS),
         .in_valid  (chain_valid[k]),
         .in_item   (chain_item[k]),
         .in_go     (chain_go[k]),
         .out_valid (chain_valid[k+1]),
         .out_item  (chain_item[k+1]),
         .out_go    (chain_go[k+1])
      );
   end

   d2p_project u_project (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (chain_valid[DIV_CELLS]),
      .in_item  (chain_item[DIV_CELLS]),
      .in_go    (chain_go[DIV_CELLS]),
      .rsp_chan (rsp_chan)
   );

endmodule
